### sv/telemetry_protobuf_frame_encoder_assert.svh
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef TELEMETRY_PROTOBUF_FRAME_ENCODER_ASSERT_SVH
`define TELEMETRY_PROTOBUF_FRAME_ENCODER_ASSERT_SVH

// same-cycle implication
`define TPFE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TPFE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/tpfe_pkg.sv
`timescale 1ns / 1ps
package tpfe_pkg;

	localparam int STAMP_W = 32;
	localparam int TICK_W  = 32;
	localparam int SECS_W  = 32;
	localparam int BATT_W  = 7;
	localparam int BYTE_W  = 8;

	localparam logic [BATT_W-1:0] BATT_RESET = 7'd101;

	localparam logic [BYTE_W-1:0] TAG_TIME    = 8'h0D;
	localparam logic [BYTE_W-1:0] TAG_METRICS = 8'h12;
	localparam logic [BYTE_W-1:0] TAG_BATTERY = 8'h08;
	localparam logic [BYTE_W-1:0] TAG_UPTIME  = 8'h28;

	// digit-serial divide by 1000, one byte of the 64-bit total per step
	localparam int MS_PER_SEC  = 1000;
	localparam int DIG_W       = 8;
	localparam int TOTAL_W     = 64;
	localparam int DIV_STEPS   = TOTAL_W / DIG_W;
	localparam int REM_W       = 10;
	localparam int V_W         = REM_W + DIG_W;
	localparam int RECIP_SHIFT = 28;
	localparam int RECIP_W     = 19;
	localparam int PROD_W      = V_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = 19'd268436; // ceil(2^28 / 1000)

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [STAMP_W-1:0] stamp;
		logic [SECS_W-1:0]  secs;
		logic [BATT_W-1:0]  batt;
	} rec_t;

endpackage

### sv/tpfe_front.sv
`timescale 1ns / 1ps
module tpfe_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [tpfe_pkg::BATT_W-1:0] cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [tpfe_pkg::STAMP_W-1:0] in_stamp,
	input  logic [tpfe_pkg::TICK_W-1:0]  in_tick,
	output logic                       rec_valid,
	input  logic                       rec_ready,
	output tpfe_pkg::rec_t             rec
);
	import tpfe_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_PUSH = 3'b100
	} state_t;

	localparam int CNT_W = $clog2(DIV_STEPS);

	state_t              st_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [TICK_W-1:0]   prev_q;
	logic [TICK_W-1:0]   wraps_q;
	logic [BATT_W-1:0]   batt_q;
	logic [REM_W-1:0]    rem_q;
	logic [TOTAL_W-1:0]  div_q;
	logic [SECS_W-1:0]   quot_q;
	logic [STAMP_W-1:0]  stamp_q;

	logic                accept;
	logic [TICK_W-1:0]   wraps_nx;
	logic [V_W-1:0]      v;
	logic [PROD_W-1:0]   prod;
	logic [DIG_W-1:0]    q;
	logic [V_W-1:0]      qk;
	logic [REM_W-1:0]    rem_nx;

	assign in_ready  = (st_q == ST_IDLE) || ((st_q == ST_PUSH) && rec_ready);
	assign accept    = in_valid && in_ready;
	assign rec_valid = (st_q == ST_PUSH);
	assign rec       = '{stamp: stamp_q, secs: quot_q, batt: batt_q};

	// backward tick step means the counter wrapped
	assign wraps_nx = wraps_q + TICK_W'(in_tick < prev_q);

	// one quotient digit: v < 256000, reciprocal exact over that range
	always_comb begin
		v      = {rem_q, div_q[TOTAL_W-1 -: DIG_W]};
		prod   = PROD_W'(v) * PROD_W'(RECIP);
		q      = prod[RECIP_SHIFT +: DIG_W];
		qk     = (V_W'(q) << 10) - (V_W'(q) << 4) - (V_W'(q) << 3);
		rem_nx = REM_W'(v - qk);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			cnt_q   <= '0;
			prev_q  <= '0;
			wraps_q <= '0;
			batt_q  <= BATT_RESET;
			rem_q   <= '0;
		end else begin
			if (cfg_we) begin
				batt_q <= cfg_wdata;
			end
			if (accept) begin
				prev_q  <= in_tick;
				wraps_q <= wraps_nx;
				rem_q   <= '0;
				cnt_q   <= '0;
				st_q    <= ST_DIV;
			end else begin
				case (st_q)
					ST_DIV: begin
						rem_q <= rem_nx;
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
							st_q <= ST_PUSH;
						end
					end
					ST_PUSH: begin
						if (rec_ready) begin
							st_q <= ST_IDLE;
						end
					end
					default: st_q <= ST_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			div_q   <= {wraps_nx, in_tick};
			stamp_q <= in_stamp;
		end else if (st_q == ST_DIV) begin
			div_q  <= div_q << DIG_W;
			quot_q <= {quot_q[SECS_W-DIG_W-1:0], q};
		end
	end

endmodule

### sv/tpfe_fifo.sv
`timescale 1ns / 1ps
module tpfe_fifo #(
	parameter int Depth = tpfe_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  tpfe_pkg::rec_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output tpfe_pkg::rec_t pop_data
);
	import tpfe_pkg::*;

	localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CNT_W = $clog2(Depth + 1);

	rec_t             mem_q [Depth];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (cnt_q != CNT_W'(Depth));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(Depth - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(Depth - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

### sv/tpfe_back.sv
`timescale 1ns / 1ps
module tpfe_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rec_valid,
	output logic                        rec_ready,
	input  tpfe_pkg::rec_t              rec,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [tpfe_pkg::BYTE_W-1:0] out_data,
	output logic                        out_last
);
	import tpfe_pkg::*;

	// byte positions in the frame
	localparam logic [3:0] POS_TAG_TIME = 4'd0;
	localparam logic [3:0] POS_STAMP0   = 4'd1;
	localparam logic [3:0] POS_STAMP1   = 4'd2;
	localparam logic [3:0] POS_STAMP2   = 4'd3;
	localparam logic [3:0] POS_STAMP3   = 4'd4;
	localparam logic [3:0] POS_TAG_MET  = 4'd5;
	localparam logic [3:0] POS_LEN      = 4'd6;
	localparam logic [3:0] POS_TAG_BAT  = 4'd7;
	localparam logic [3:0] POS_BATT     = 4'd8;
	localparam logic [3:0] POS_TAG_UPT  = 4'd9;
	localparam logic [3:0] POS_VARINT   = 4'd10;
	localparam int VAR_BITS = 7;
	localparam int VAR_MAX  = 5;

	rec_t                     cur_q;
	logic                     active_q;
	logic [3:0]               idx_q;
	logic [3:0]               last_idx_q;
	logic [2:0]               ulen_q;
	logic                     out_valid_q;
	logic [BYTE_W-1:0]        out_data_q;
	logic                     out_last_q;

	logic                     emit;
	logic                     cur_last;
	logic                     pop;
	logic [2:0]               ulen_nx;
	logic [2:0]               k;
	logic [VAR_BITS*VAR_MAX-1:0] secs_ext;
	logic [BYTE_W-1:0]        byte_sel;

	function automatic logic [2:0] varint_len(input logic [SECS_W-1:0] s);
		if (s[SECS_W-1:7] == '0) begin
			return 3'd1;
		end else if (s[SECS_W-1:14] == '0) begin
			return 3'd2;
		end else if (s[SECS_W-1:21] == '0) begin
			return 3'd3;
		end else if (s[SECS_W-1:28] == '0) begin
			return 3'd4;
		end
		return 3'd5;
	endfunction

	assign emit      = active_q && (!out_valid_q || out_ready);
	assign cur_last  = (idx_q == last_idx_q);
	assign rec_ready = !active_q || (emit && cur_last);
	assign pop       = rec_valid && rec_ready;
	assign ulen_nx   = varint_len(rec.secs);

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

	always_comb begin
		k        = 3'(idx_q - POS_VARINT);
		secs_ext = (VAR_BITS*VAR_MAX)'(cur_q.secs);
		case (idx_q)
			POS_TAG_TIME: byte_sel = TAG_TIME;
			POS_STAMP0:   byte_sel = cur_q.stamp[7:0];
			POS_STAMP1:   byte_sel = cur_q.stamp[15:8];
			POS_STAMP2:   byte_sel = cur_q.stamp[23:16];
			POS_STAMP3:   byte_sel = cur_q.stamp[31:24];
			POS_TAG_MET:  byte_sel = TAG_METRICS;
			POS_LEN:      byte_sel = BYTE_W'(ulen_q) + 8'd3;
			POS_TAG_BAT:  byte_sel = TAG_BATTERY;
			POS_BATT:     byte_sel = {1'b0, cur_q.batt};
			POS_TAG_UPT:  byte_sel = TAG_UPTIME;
			default:      byte_sel = {(k != 3'(ulen_q - 3'd1)), secs_ext[k*VAR_BITS +: VAR_BITS]};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				active_q <= 1'b1;
				idx_q    <= '0;
			end else if (emit) begin
				idx_q <= idx_q + 1'b1;
				if (cur_last) begin
					active_q <= 1'b0;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q      <= rec;
			ulen_q     <= ulen_nx;
			last_idx_q <= POS_TAG_UPT + 4'(ulen_nx);
		end
		if (emit) begin
			out_data_q <= byte_sel;
			out_last_q <= cur_last;
		end
	end

endmodule

### sv/telemetry_protobuf_frame_encoder.sv
`timescale 1ns / 1ps
// telemetry frame encoder, protobuf wire format
// s_axis: one transaction per frame, tdata = {tick_ms, time_stamp}
// m_axis: one transaction per frame byte, tlast on the final byte
// cfg_we / cfg_wdata: battery level written at any edge with cfg_we high
// frame: 0x0d, stamp le x4, 0x12, len, 0x08, battery, 0x28, uptime varint
// frames run 11 to 15 bytes, one byte per cycle while the receiver is ready
// front: tick wrap tracking and a digit-serial divide of the 64-bit
//   millisecond total by 1000, one byte per cycle
// a two-entry queue sits between front and back, each stalls on its own
// back: byte serializer with an output register, so the next frame loads
//   the cycle its predecessor's last byte is issued
// when idle, the first byte passes the divider steps, the queue and the output register
// the serializer sets the frame rate; the front takes a new input as its record enters the queue
// reset: battery level 101, tick history and wrap count cleared, queue empty
// receiver stall: output holds, queue fills, then s_axis_tready drops
module telemetry_protobuf_frame_encoder #(
	parameter int QueueDepth = tpfe_pkg::QUEUE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [tpfe_pkg::BATT_W-1:0]  cfg_wdata,      // battery_level
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [63:0]                  s_axis_tdata,   // time_stamp, tick_ms
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [tpfe_pkg::BYTE_W-1:0]  m_axis_tdata,   // frame_byte
	output logic                         m_axis_tlast    // last_byte
);
	import tpfe_pkg::*;

	`include "telemetry_protobuf_frame_encoder_assert.svh"

	logic front_valid;
	logic front_ready;
	rec_t front_rec;
	logic back_valid;
	logic back_ready;
	rec_t back_rec;

	// classify: wrap tracking and uptime seconds
	tpfe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_stamp  (s_axis_tdata[STAMP_W-1:0]),
		.in_tick   (s_axis_tdata[STAMP_W +: TICK_W]),
		.rec_valid (front_valid),
		.rec_ready (front_ready),
		.rec       (front_rec)
	);

	// decoupling queue of frame records
	tpfe_fifo #(
		.Depth (QueueDepth)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (front_rec),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_data   (back_rec)
	);

	// serialize one record into frame bytes
	tpfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (back_valid),
		.rec_ready (back_ready),
		.rec       (back_rec),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

	// divider busy right after an input transaction
	`TPFE_ASSERT_NXT(a_div_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while divider busy")
	// a frame opens with the time tag
	`TPFE_ASSERT_IMP(a_frame_start, m_axis_tvalid && m_axis_tready && $past(m_axis_tvalid && m_axis_tready && m_axis_tlast), m_axis_tdata == TAG_TIME, "frame does not start with time tag")
	// closing varint byte has no continuation bit
	`TPFE_ASSERT_IMP(a_last_varint, m_axis_tvalid && m_axis_tlast, !m_axis_tdata[BYTE_W-1], "last byte carries continuation bit")

endmodule
